FILE: sv/tpi_pkg.sv
`default_nettype none
package tpi_pkg;

  // field widths
  localparam int NW     = 16;           // Q1.14 normal component
  localparam int DISTW  = 32;           // Q16.16 distance / coordinate
  localparam int CW     = 33;           // cross product component, 2^-28 units
  localparam int DETW   = 51;           // signed determinant, 2^-42 units
  localparam int MAGW   = DETW - 1;     // determinant magnitude
  localparam int NUMW   = 66;           // signed numerator, 2^-44 units
  localparam int QW     = NUMW + 14;    // dividend and quotient width
  localparam int EPSW   = 29;
  localparam int DIV_STEPS = QW;        // one quotient bit per stage

  localparam logic [EPSW-1:0] EPS_RST = EPSW'(26844);

  localparam logic [DISTW-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [DISTW-1:0] NEG_MAX = 32'h8000_0000;

  typedef logic signed [NW-1:0] nrm_t;
  typedef nrm_t [2:0]           nvec_t;
  typedef logic signed [CW-1:0] crs_t;
  typedef crs_t [2:0]           cvec_t;
  typedef logic [MAGW-1:0]      rem_t;
  typedef logic [QW-1:0]        quo_t;
  typedef quo_t [2:0]           quo3_t;
  typedef rem_t [2:0]           rem3_t;

  // side information travelling with an item through the divider
  typedef struct packed {
    logic       exists;
    logic [2:0] neg;
  } ctl_t;

  typedef struct packed {
    logic              exists;
    logic              sat;
    logic [DISTW-1:0]  x;
    logic [DISTW-1:0]  y;
    logic [DISTW-1:0]  z;
  } res_t;

  // u x v, exact
  function automatic cvec_t cross3(nvec_t u, nvec_t v);
    cvec_t c;
    c[0] = CW'($signed(u[1])) * CW'($signed(v[2])) - CW'($signed(u[2])) * CW'($signed(v[1]));
    c[1] = CW'($signed(u[2])) * CW'($signed(v[0])) - CW'($signed(u[0])) * CW'($signed(v[2]));
    c[2] = CW'($signed(u[0])) * CW'($signed(v[1])) - CW'($signed(u[1])) * CW'($signed(v[0]));
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/three_plane_intersection.sv
// Three plane intersection. Each input transaction carries three planes (Q1.14 normal,
// Q16.16 distance); each output transaction carries the common point in Q16.16, rounded
// to nearest with halves away from zero and saturated, with tuser flagging whether the
// point exists (|det| above det_epsilon * 2^-28) and whether a coordinate was clamped.
// The block takes one transaction per clock unless stalled, and passes it through:
// one stage of cross products, one of products with the normals and distances, one of
// sums and the epsilon test, 80 stages of a restoring divider producing one quotient
// bit each, and a rounding stage that writes a two-entry output buffer. The buffer
// lets input flow on while a result waits; the pipeline stalls only when it is full.
`default_nettype none
module three_plane_intersection
  import tpi_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration: det_epsilon
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [28:0]  cfg_data,
  // input planes
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // from bit 0: plane_a_nx, plane_a_ny, plane_a_nz, plane_a_dist, plane_b_nx,
  // plane_b_ny, plane_b_nz, plane_b_dist, plane_c_nx, plane_c_ny, plane_c_nz, plane_c_dist
  input  wire logic [239:0] in_tdata,
  // result point
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // from bit 0: point_x, point_y, point_z
  output logic [95:0]       out_tdata,
  // from bit 0: point_exists, coord_saturated
  output logic [1:0]        out_tuser
);

  logic [EPSW-1:0] eps_r;
  logic            en;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RST;
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  // unpack planes
  nvec_t           n_in [3];
  logic [DISTW-1:0] d_in [3];
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        n_in[p][k] = in_tdata[p*80 + k*16 +: 16];
      end
      d_in[p] = in_tdata[p*80 + 48 +: 32];
    end
  end

  // stage 1: cross products
  logic  s1_v_r;
  nvec_t s1_na_r;
  cvec_t s1_c_r [3];
  logic [DISTW-1:0] s1_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_na_r  <= n_in[0];
      s1_c_r[0] <= cross3(n_in[1], n_in[2]);
      s1_c_r[1] <= cross3(n_in[2], n_in[0]);
      s1_c_r[2] <= cross3(n_in[0], n_in[1]);
      for (int p = 0; p < 3; p++) begin
        s1_d_r[p] <= d_in[p];
      end
    end
  end

  // stage 2: determinant and numerator partial products
  logic                   s2_v_r;
  logic signed [DETW-1:0] s2_pd_r [3];
  logic signed [NUMW-1:0] s2_pn_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_pd_r[k] <= DETW'($signed(s1_na_r[k])) * DETW'($signed(s1_c_r[0][k]));
        for (int p = 0; p < 3; p++) begin
          s2_pn_r[p][k] <= NUMW'($signed(s1_c_r[p][k])) * NUMW'($signed(s1_d_r[p]));
        end
      end
    end
  end

  // stage 3: sums, magnitudes and the epsilon test
  logic signed [DETW-1:0] det_s;
  logic [DETW-1:0]        det_neg;
  rem_t                   det_mag;
  logic signed [NUMW-1:0] num_s [3];
  logic [NUMW-1:0]        num_mag [3];
  quo3_t                  num_q;
  ctl_t                   ctl_s3;

  always_comb begin
    det_s   = s2_pd_r[0] + s2_pd_r[1] + s2_pd_r[2];
    det_neg = -det_s;
    det_mag = det_s[DETW-1] ? det_neg[MAGW-1:0] : det_s[MAGW-1:0];
    ctl_s3.exists = det_mag > MAGW'({eps_r, 14'd0});
    for (int k = 0; k < 3; k++) begin
      num_s[k]      = s2_pn_r[0][k] + s2_pn_r[1][k] + s2_pn_r[2][k];
      num_mag[k]    = num_s[k][NUMW-1] ? NUMW'(-num_s[k]) : NUMW'(num_s[k]);
      num_q[k]      = {num_mag[k], 14'd0};
      ctl_s3.neg[k] = num_s[k][NUMW-1] ^ det_s[DETW-1];
    end
  end

  logic  s3_v_r;
  ctl_t  s3_ctl_r;
  rem_t  s3_den_r;
  quo3_t s3_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctl_r <= ctl_s3;
      s3_den_r <= det_mag;
      s3_num_r <= num_q;
    end
  end

  // pipelined divider
  logic  dv_v;
  ctl_t  dv_ctl;
  rem_t  dv_den;
  quo3_t dv_q;
  rem3_t dv_rem;

  tpi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_ctl    (s3_ctl_r),
    .in_den    (s3_den_r),
    .in_num    (s3_num_r),
    .out_valid (dv_v),
    .out_ctl   (dv_ctl),
    .out_den   (dv_den),
    .out_q     (dv_q),
    .out_rem   (dv_rem)
  );

  // rounding, sign and saturation
  res_t           res;
  logic [QW:0]    q1 [3];
  logic           up [3];
  logic           sat_k [3];
  logic [DISTW-1:0] val_k [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      up[k]    = {dv_rem[k], 1'b0} >= {1'b0, dv_den};
      q1[k]    = {1'b0, dv_q[k]} + (QW+1)'(up[k]);
      sat_k[k] = (|q1[k][QW:DISTW]) ||
                 (dv_ctl.neg[k] ? (q1[k][DISTW-1] && (|q1[k][DISTW-2:0])) : q1[k][DISTW-1]);
      if (sat_k[k]) begin
        val_k[k] = dv_ctl.neg[k] ? NEG_MAX : POS_MAX;
      end else begin
        val_k[k] = dv_ctl.neg[k] ? -q1[k][DISTW-1:0] : q1[k][DISTW-1:0];
      end
    end
    res.exists = dv_ctl.exists;
    res.sat    = dv_ctl.exists && (sat_k[0] || sat_k[1] || sat_k[2]);
    res.x      = dv_ctl.exists ? val_k[0] : '0;
    res.y      = dv_ctl.exists ? val_k[1] : '0;
    res.z      = dv_ctl.exists ? val_k[2] : '0;
  end

  // two-entry output buffer
  res_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign en         = !(cnt_r == 2'd2 && !out_tready);
  assign in_tready  = en;
  assign push       = en && dv_v;
  assign out_tvalid = cnt_r != 2'd0;
  assign pop        = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_tdata = {fifo_r[rd_ptr_r].z, fifo_r[rd_ptr_r].y, fifo_r[rd_ptr_r].x};
  assign out_tuser = {fifo_r[rd_ptr_r].sat, fifo_r[rd_ptr_r].exists};

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output buffer count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0 && !out_tuser[1]))
    else $error("missing point carries data");

  a_sat_exists: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.sat) |-> res.exists) else $error("saturation without a point");

  a_eps_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> eps_r == $past(cfg_data))
    else $error("epsilon write lost");

endmodule
`default_nettype wire

FILE: sv/tpi_div.sv
`default_nettype none
module tpi_div
  import tpi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire ctl_t  in_ctl,
  input  wire rem_t  in_den,
  input  wire quo3_t in_num,
  output logic       out_valid,
  output ctl_t       out_ctl,
  output rem_t       out_den,
  output quo3_t      out_q,
  output rem3_t      out_rem
);

  // per stage registers: dividend bits shift out at the top, quotient bits in at the bottom
  logic  v_r   [DIV_STEPS];
  ctl_t  ctl_r [DIV_STEPS];
  rem_t  den_r [DIV_STEPS];
  quo3_t nq_r  [DIV_STEPS];
  rem3_t rem_r [DIV_STEPS];

  // one restoring step
  function automatic logic [MAGW+QW-1:0] step(rem_t rem, quo_t nq, rem_t den);
    logic [MAGW:0] trial;
    logic [MAGW:0] diff;
    logic          bit_q;
    rem_t          rem_n;
    trial = {rem, nq[QW-1]};
    diff  = trial - {1'b0, den};
    bit_q = ~diff[MAGW];
    rem_n = bit_q ? diff[MAGW-1:0] : trial[MAGW-1:0];
    return {rem_n, nq[QW-2:0], bit_q};
  endfunction

  genvar s, k;
  generate
    for (s = 0; s < DIV_STEPS; s++) begin : g_stage
      logic  v_in;
      ctl_t  ctl_in;
      rem_t  den_in;
      quo3_t nq_in;
      rem3_t rem_in;
      quo3_t nq_nxt;
      rem3_t rem_nxt;

      if (s == 0) begin : g_first
        assign v_in   = in_valid;
        assign ctl_in = in_ctl;
        assign den_in = in_den;
        assign nq_in  = in_num;
        assign rem_in = '0;
      end else begin : g_next
        assign v_in   = v_r[s-1];
        assign ctl_in = ctl_r[s-1];
        assign den_in = den_r[s-1];
        assign nq_in  = nq_r[s-1];
        assign rem_in = rem_r[s-1];
      end

      for (k = 0; k < 3; k++) begin : g_lane
        assign {rem_nxt[k], nq_nxt[k]} = step(rem_in[k], nq_in[k], den_in);
      end

      // valid bit
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en) begin
          v_r[s] <= v_in;
        end
      end

      // payload
      always_ff @(posedge clk) begin
        if (en) begin
          ctl_r[s] <= ctl_in;
          den_r[s] <= den_in;
          nq_r[s]  <= nq_nxt;
          rem_r[s] <= rem_nxt;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[DIV_STEPS-1];
  assign out_ctl   = ctl_r[DIV_STEPS-1];
  assign out_den   = den_r[DIV_STEPS-1];
  assign out_q     = nq_r[DIV_STEPS-1];
  assign out_rem   = rem_r[DIV_STEPS-1];

endmodule
`default_nettype wire

FILE: dv/three_plane_checker.sv
`default_nettype none
module three_plane_checker
  import tpi_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [28:0]  cfg_data,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [239:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [95:0]  out_tdata,
  input  wire logic [1:0]   out_tuser,
  output int                fail_count,
  output int                pending_count,
  output int                point_count,
  output int                sat_count
);

  typedef struct packed {
    logic        exists;
    logic        sat;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  logic [28:0] eps_shadow;
  point_t      expected_points[$];

  // rounded, saturated quotient of a numerator over the determinant
  function automatic logic [31:0] divide_coord(logic signed [127:0] num, longint det,
                                               inout logic sat);
    logic         neg;
    logic [159:0] nm, dm, q, r, limit;
    neg   = (num < 0) != (det < 0);
    nm    = 160'(num < 0 ? -num : num) << 14;
    dm    = 160'(det < 0 ? -det : det);
    q     = nm / dm;
    r     = nm % dm;
    if (r >= dm - r) q = q + 1;
    limit = neg ? 160'h8000_0000 : 160'h7fff_ffff;
    if (q > limit) begin
      sat = 1'b1;
      return neg ? NEG_MAX : POS_MAX;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  // common point of the three planes carried by one transaction
  function automatic point_t predict_point(logic [239:0] pl, logic [28:0] eps);
    longint              n[3][3];
    longint              plane_dist[3];
    longint              c[3][3];
    longint              det;
    longint              adet;
    logic signed [127:0] num;
    logic                sat;
    point_t              p;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) n[i][k] = longint'($signed(pl[i*80 + k*16 +: 16]));
      plane_dist[i] = longint'($signed(pl[i*80 + 48 +: 32]));
    end
    for (int i = 0; i < 3; i++) begin
      c[i][0] = n[(i+1)%3][1] * n[(i+2)%3][2] - n[(i+1)%3][2] * n[(i+2)%3][1];
      c[i][1] = n[(i+1)%3][2] * n[(i+2)%3][0] - n[(i+1)%3][0] * n[(i+2)%3][2];
      c[i][2] = n[(i+1)%3][0] * n[(i+2)%3][1] - n[(i+1)%3][1] * n[(i+2)%3][0];
    end
    det  = n[0][0] * c[0][0] + n[0][1] * c[0][1] + n[0][2] * c[0][2];
    adet = det < 0 ? -det : det;
    p    = '0;
    if (adet <= (longint'(eps) << 14)) return p;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      num = 128'(c[0][k]) * 128'(plane_dist[0]) + 128'(c[1][k]) * 128'(plane_dist[1])
          + 128'(c[2][k]) * 128'(plane_dist[2]);
      case (k)
        0: p.x = divide_coord(num, det, sat);
        1: p.y = divide_coord(num, det, sat);
        default: p.z = divide_coord(num, det, sat);
      endcase
    end
    p.exists = 1'b1;
    p.sat    = sat;
    return p;
  endfunction

  // track the register, queue predictions, compare results
  always @(posedge clk) begin
    point_t e;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      eps_shadow <= EPS_RST;
      fail_count <= 0;
      point_count <= 0;
      sat_count <= 0;
      pending_count <= 0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) eps_shadow <= cfg_data;
      if (in_tvalid && in_tready) expected_points.push_back(predict_point(in_tdata, eps_shadow));
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("result transaction with nothing expected");
          errs++;
        end else begin
          e = expected_points.pop_front();
          point_count <= point_count + e.exists;
          sat_count <= sat_count + e.sat;
          if (out_tuser[0] !== e.exists) begin
            $error("point_exists: expected %0d, got %0d", e.exists, out_tuser[0]);
            errs++;
          end
          if (out_tuser[1] !== e.sat) begin
            $error("coord_saturated: expected %0d, got %0d", e.sat, out_tuser[1]);
            errs++;
          end
          if (out_tdata[31:0] !== e.x) begin
            $error("point_x: expected %h, got %h", e.x, out_tdata[31:0]);
            errs++;
          end
          if (out_tdata[63:32] !== e.y) begin
            $error("point_y: expected %h, got %h", e.y, out_tdata[63:32]);
            errs++;
          end
          if (out_tdata[95:64] !== e.z) begin
            $error("point_z: expected %h, got %h", e.z, out_tdata[95:64]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= expected_points.size();
    end
  end

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 100;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [28:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // from bit 0: plane a nx, ny, nz, dist, plane b ..., plane c ...
  logic [239:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // from bit 0: point_x, point_y, point_z
  logic [95:0]  out_tdata;
  // from bit 0: point_exists, coord_saturated
  logic [1:0]   out_tuser;

  int fail_count, pending_count, point_count, sat_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  logic hold_done = 1'b0;
  int sent_items = 0;
  longint cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  three_plane_intersection uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  three_plane_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_count(pending_count),
    .point_count(point_count), .sat_count(sat_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", pending_count);
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin
    int hold_left;
    if (hold_request > 0 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = hold_request;
      while (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
        @(posedge clk);
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [239:0] planes(int ax, int ay, int az, int ad, int bx, int by,
                                          int bz, int bd, int cx, int cy, int cz, int cd);
    return {cd, cz[15:0], cy[15:0], cx[15:0], bd, bz[15:0], by[15:0], bx[15:0],
            ad, az[15:0], ay[15:0], ax[15:0]};
  endfunction

  function automatic int rand_normal();
    return int'($urandom_range(32768)) - 16384;
  endfunction

  function automatic int rand_dist();
    return ($urandom_range(1) == 0) ? int'($urandom) : int'($urandom_range(2000000)) - 1000000;
  endfunction

  // offer one plane triple, with random idle cycles before it
  task automatic send_planes(logic [239:0] pl);
    logic ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pl;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    sent_items++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [28:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random();
    int a[4], b[4], c[4];
    int kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 3; k++) begin
      a[k] = rand_normal();
      b[k] = rand_normal();
      c[k] = rand_normal();
      // tiny normals give determinants near zero
      if (kind == 2) begin
        a[k] = a[k] % 8;
        b[k] = b[k] % 8;
        c[k] = c[k] % 8;
      end
    end
    a[3] = rand_dist();
    b[3] = rand_dist();
    c[3] = rand_dist();
    // parallel or nearly parallel planes
    if (kind == 1) begin
      for (int k = 0; k < 3; k++) c[k] = ($urandom_range(1) == 0) ? a[k] : -a[k];
      if ($urandom_range(1) == 0) c[$urandom_range(2)] += $urandom_range(6) - 3;
    end
    send_planes(planes(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3],
                       c[0], c[1], c[2], c[3]));
  endtask

  initial begin
    logic [28:0] eps_values[5];
    eps_values = '{29'd0, 29'd268435456, 29'd1000, 29'd0, 29'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: axis planes, extremes, degenerate sets, threshold and overflow
    send_planes(planes(16384, 0, 0, 65536, 0, 16384, 0, -131072, 0, 0, 16384, 98304));
    send_planes(planes(-16384, 0, 0, 32'h7fffffff, 0, -16384, 0, 32'h80000000,
                       0, 0, -16384, 0));
    send_planes(planes(16383, 1, 0, 12345, -2, 16383, 3, -777, 0, 5, 16383, 1));
    send_planes(planes(16384, 16384, 16384, 32'h7fffffff, -16384, 16384, -16384,
                       32'h80000000, 16384, -16384, -16384, 32'h7fffffff));
    send_planes(planes(-16384, -16384, -16384, 5, -16384, -16384, -16384, 6,
                       -16384, -16384, -16384, 7));
    send_planes(planes(100, 200, 300, 1, 7, 8, 9, 2, 100, 200, 300, 1));
    send_planes(planes(16384, 0, 0, 0, 16384, 1, 0, 0, 0, 0, 16384, 0));
    send_planes(planes(16384, 0, 0, 65536, 16384, 2, 0, 32'h7fffffff, 0, 0, 16384, 0));
    send_planes(planes(16384, 0, 0, 0, 16384, 2, 0, 32'h80000000, 0, 0, 16384, 0));
    send_planes(planes(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_planes(planes(3, 0, 0, 1, 0, 3, 0, 1, 0, 0, 3, 1));
    send_planes(planes(16384, 0, 0, 1, 0, 16384, 0, -1, 0, 0, 16384, 32768));
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        eps_values[3] = 29'($urandom_range(268435456));
        eps_values[4] = 29'd26844;
        write_epsilon(eps_values[ph - 1]);
      end
      for (int sub = 0; sub < 4; sub++) begin
        send_idle_pct  = (sub == 1) ? 58 : (sub == 3) ? 22 : 0;
        recv_stall_pct = (sub == 2) ? 58 : (sub == 3) ? 22 : 0;
        // downstream backs off for a long time so the block fills up
        if (ph == 1 && sub == 0) hold_request = 400;
        repeat (65) send_random();
      end
      wait_idle();
    end

    $display("%0d plane triples over five threshold settings, %0d with a point",
             sent_items, point_count);
    $display("%0d results clamped a coordinate", sat_count);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
sv/tpi_pkg.sv
sv/tpi_div.sv
sv/three_plane_intersection.sv
dv/three_plane_checker.sv
dv/testbench.sv
